// ===== rtl/csb_pkg.sv =====
`default_nettype none
package csb_pkg;

  localparam int STORE_DEPTH_DEF = 32;
  localparam int DATA_WIDTH_DEF  = 32;

  typedef enum logic [2:0] {
    ACT_START   = 3'd0,
    ACT_ADVANCE = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_ATTACH  = 3'd3,
    ACT_REMOVE  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FULL       = 2'd1,
    ST_NO_CURRENT = 2'd2
  } status_t;

  // Kind of store edit planned for the item in flight
  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_GROW   = 2'd1,
    MODE_SHRINK = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_RD,
    S_WR,
    S_FINISH,
    S_FETCH,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_shift;
    logic wr_shift;
    logic commit;
    logic fetch;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic shift_more;
    logic out_blocked;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/cursor_sequence_buffer_core.sv =====
`default_nettype none
// Ordered store of up to STORE_DEPTH words with a cursor.
// Input channel (in_valid / in_stall) carries an action code and a data word:
// start, advance, insert before cursor, attach after cursor, remove current.
// Result channel (out_valid / out_stall) returns one item per input item:
// the word under the cursor (zero if none), the has-current flag, the item
// count and a status (done, refused full, refused no current item).
// Items are handled one at a time. An item that moves stored words
// (insert/attach: words from the target position up, remove: words behind
// the cursor) is planned, moves each word, then commits, fetches the word
// under the cursor and loads the output register; each moved word costs a
// RAM read, a write-back and a check for the next word. A new item is not
// taken before the last is through: it is taken when the block returns to
// idle, even while the previous result still waits in the output register.
// A stall on the result side holds the output register; a new result waits
// for it to empty, and the input stays stalled meanwhile.
// Synchronous reset empties the store and puts the cursor at the front; the
// store contents themselves are not cleared, no clearing pass is needed.
module cursor_sequence_buffer_core import csb_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  localparam int CW = $clog2(STORE_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            in_action,
  input  wire logic [DATA_WIDTH-1:0] in_entry_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [DATA_WIDTH-1:0] out_current_value,
  output logic                       out_has_current,
  output logic      [CW-1:0]         out_item_count,
  output logic      [1:0]            out_status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  csb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  csb_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_action         (in_action),
    .in_entry_value    (in_entry_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_current_value (out_current_value),
    .out_has_current   (out_has_current),
    .out_item_count    (out_item_count),
    .out_status        (out_status)
  );

endmodule
`default_nettype wire

// ===== rtl/csb_ram.sv =====
`default_nettype none
module csb_ram import csb_pkg::*; #(
  parameter int WIDTH = DATA_WIDTH_DEF,
  parameter int DEPTH = STORE_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/csb_ctrl.sv =====
`default_nettype none
module csb_ctrl import csb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PLAN;
        end
      end
      S_PLAN: begin
        state_nxt = stat.shift_more ? S_RD : S_FINISH;
      end
      S_RD: begin
        cmd.rd_shift = 1'b1;
        state_nxt    = S_WR;
      end
      S_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_PLAN;
      end
      S_FINISH: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register is free
        if (!stat.out_blocked) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_plans: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == S_PLAN)
    else $error("accepted item did not enter planning");
  a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_shift |=> cmd.wr_shift)
    else $error("shift read not followed by its write");
  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");
`endif

endmodule
`default_nettype wire

// ===== rtl/csb_datapath.sv =====
`default_nettype none
module csb_datapath import csb_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
  localparam int CW = $clog2(STORE_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  input  wire logic [2:0]            in_action,
  input  wire logic [DATA_WIDTH-1:0] in_entry_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [DATA_WIDTH-1:0] out_current_value,
  output logic                       out_has_current,
  output logic      [CW-1:0]         out_item_count,
  output logic      [1:0]            out_status
);

  localparam logic [CW-1:0] FULL_COUNT = CW'(STORE_DEPTH);

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         cur_r, cur_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  mode_t                 mode_r, mode_nxt;
  status_t               stat_r, stat_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_value_r, out_value_nxt;
  logic                  out_has_r, out_has_nxt;
  logic [CW-1:0]         out_cnt_r, out_cnt_nxt;
  status_t               out_stat_r, out_stat_nxt;

  logic                  on_item;
  logic                  full;
  logic [CW-1:0]         idx_dec;
  logic [CW-1:0]         shift_src;
  logic [CW-1:0]         shift_dst;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign on_item   = cur_r < cnt_r;
  assign full      = cnt_r == FULL_COUNT;
  assign idx_dec   = idx_r - 1'b1;
  // growing moves items up from the top, shrinking moves them down from the gap
  assign shift_src = (mode_r == MODE_GROW) ? idx_dec : idx_r;
  assign shift_dst = (mode_r == MODE_GROW) ? idx_r : idx_dec;

  always_comb begin
    stat.out_blocked = out_valid_r && out_stall;
    unique case (mode_r)
      MODE_GROW:   stat.shift_more = idx_r > pos_r;
      MODE_SHRINK: stat.shift_more = idx_r < cnt_r;
      default:     stat.shift_more = 1'b0;
    endcase
  end

  assign ram_we    = cmd.wr_shift || (cmd.commit && mode_r == MODE_GROW);
  assign ram_waddr = cmd.commit ? pos_r[AW-1:0] : shift_dst[AW-1:0];
  assign ram_wdata = cmd.commit ? word_r : ram_rdata;
  assign ram_re    = cmd.rd_shift || (cmd.fetch && on_item);
  assign ram_raddr = cmd.fetch ? cur_r[AW-1:0] : shift_src[AW-1:0];

  csb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cnt_nxt  = cnt_r;
    cur_nxt  = cur_r;
    pos_nxt  = pos_r;
    idx_nxt  = idx_r;
    mode_nxt = mode_r;
    stat_nxt = stat_r;
    word_nxt = word_r;

    if (cmd.accept) begin
      word_nxt = in_entry_value;
      stat_nxt = ST_DONE;
      mode_nxt = MODE_NONE;
      unique case (action_t'(in_action))
        ACT_START: begin
          cur_nxt = '0;
        end
        ACT_ADVANCE: begin
          if (on_item) begin
            cur_nxt = cur_r + 1'b1;
          end
        end
        ACT_INSERT: begin
          if (full) begin
            stat_nxt = ST_FULL;
          end else begin
            mode_nxt = MODE_GROW;
            pos_nxt  = on_item ? cur_r : '0;
            idx_nxt  = cnt_r;
          end
        end
        ACT_ATTACH: begin
          if (full) begin
            stat_nxt = ST_FULL;
          end else begin
            mode_nxt = MODE_GROW;
            idx_nxt  = cnt_r;
            if (cnt_r == '0) begin
              pos_nxt = '0;
            end else begin
              pos_nxt = on_item ? cur_r + 1'b1 : cnt_r;
            end
          end
        end
        ACT_REMOVE: begin
          if (!on_item) begin
            stat_nxt = ST_NO_CURRENT;
          end else begin
            mode_nxt = MODE_SHRINK;
            pos_nxt  = cur_r;
            idx_nxt  = cur_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.wr_shift) begin
      idx_nxt = (mode_r == MODE_GROW) ? idx_dec : idx_r + 1'b1;
    end

    if (cmd.commit) begin
      unique case (mode_r)
        MODE_GROW: begin
          cnt_nxt = cnt_r + 1'b1;
          cur_nxt = pos_r;
        end
        MODE_SHRINK: begin
          cnt_nxt = cnt_r - 1'b1;
        end
        default: begin
        end
      endcase
      mode_nxt = MODE_NONE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_has_nxt   = out_has_r;
    out_cnt_nxt   = out_cnt_r;
    out_stat_nxt  = out_stat_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
      out_has_nxt   = on_item;
      out_value_nxt = on_item ? ram_rdata : '0;
      out_cnt_nxt   = cnt_r;
      out_stat_nxt  = stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      cur_r       <= '0;
      mode_r      <= MODE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    idx_r       <= idx_nxt;
    stat_r      <= stat_nxt;
    word_r      <= word_nxt;
    out_value_r <= out_value_nxt;
    out_has_r   <= out_has_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_current_value = out_value_r;
  assign out_has_current   = out_has_r;
  assign out_item_count    = out_cnt_r;
  assign out_status        = out_stat_r;

`ifndef NO_ASSERTIONS
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= cnt_r)
    else $error("cursor beyond stored count");
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_COUNT)
    else $error("stored count beyond depth");
  a_grow_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && mode_r == MODE_GROW) |-> !full)
    else $error("store written while full");
  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_shift |-> (shift_dst < FULL_COUNT && shift_src < FULL_COUNT))
    else $error("shift address outside the store");
`endif

endmodule
`default_nettype wire
